### hw/rtl/spit_pkg.sv
// shared types, constants and codes for the sorted peer id table
package spit_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ID_BITS     = 16;

  localparam int ID_W   = ID_BITS;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PORT_W = 16;
  localparam int POS_W  = 6;
  localparam int ECNT_W = 7;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RES
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    logic              acc;
  } entry_t;

  typedef struct packed {
    logic g;
    logic ge;
    logic eq;
  } flags_t;

  typedef struct packed {
    logic cap;
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

### hw/rtl/spit_cell.sv
// one table slot: entry storage, key compare and neighbor shift
module spit_cell (
  input  logic                        clk,
  input  logic [spit_pkg::IDX_W-1:0]  idx,
  input  logic [spit_pkg::CNT_W-1:0]  count,
  input  logic [spit_pkg::ID_W-1:0]   key,
  input  spit_pkg::cell_cmd_t         cmd,
  input  spit_pkg::entry_t            new_ent,
  input  spit_pkg::entry_t            left_ent,
  input  spit_pkg::entry_t            right_ent,
  input  spit_pkg::flags_t            left_flg,
  output spit_pkg::entry_t            ent,
  output spit_pkg::flags_t            flg,
  output logic                        lo_bnd,
  output logic                        up_bnd
);

  spit_pkg::entry_t ent_r, ent_nxt;
  spit_pkg::flags_t flg_r, flg_nxt;
  logic             valid;
  logic             at_end;

  assign valid  = spit_pkg::CNT_W'(idx) < count;
  assign at_end = spit_pkg::CNT_W'(idx) == count;

  always_comb begin
    flg_nxt = flg_r;
    if (cmd.cap) begin
      flg_nxt.g  = valid && (ent_r.id > key);
      flg_nxt.ge = valid && (ent_r.id >= key);
      flg_nxt.eq = ent_r.id == key;
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (left_flg.g) begin
        ent_nxt = left_ent;
      end else if (at_end || flg_r.g) begin
        ent_nxt = new_ent;
      end
    end else if (cmd.rem && flg_r.ge) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    flg_r <= flg_nxt;
  end

  // first slot not below the key, first slot above it (or the free slot)
  assign lo_bnd = flg_r.ge && !left_flg.ge;
  assign up_bnd = (at_end || flg_r.g) && !left_flg.g;

  assign ent = ent_r;
  assign flg = flg_r;

endmodule

### hw/rtl/spit_reduce.sv
// one-hot boundary reduction to position, hit and matching entry
module spit_reduce (
  input  logic [spit_pkg::TABLE_DEPTH-1:0]             lo_bnd,
  input  logic [spit_pkg::TABLE_DEPTH-1:0]             up_bnd,
  input  logic [spit_pkg::TABLE_DEPTH-1:0]             eq,
  input  spit_pkg::entry_t [spit_pkg::TABLE_DEPTH-1:0] ents,
  output logic                                         lo_hit,
  output logic [spit_pkg::IDX_W-1:0]                   lo_pos,
  output logic [spit_pkg::PORT_W-1:0]                  lo_port,
  output logic                                         lo_acc,
  output logic [spit_pkg::IDX_W-1:0]                   up_pos
);

  always_comb begin
    lo_hit  = 1'b0;
    lo_pos  = '0;
    lo_port = '0;
    lo_acc  = 1'b0;
    up_pos  = '0;
    for (int i = 0; i < spit_pkg::TABLE_DEPTH; i++) begin
      if (lo_bnd[i] && eq[i]) begin
        lo_hit  = 1'b1;
        lo_pos  = lo_pos | spit_pkg::IDX_W'(i);
        lo_port = lo_port | ents[i].port;
        lo_acc  = lo_acc | ents[i].acc;
      end
      if (up_bnd[i]) begin
        up_pos = up_pos | spit_pkg::IDX_W'(i);
      end
    end
  end

endmodule

### hw/rtl/sorted_peer_id_table.sv
// top level of the sorted peer id table: request sequencer, cell row, result register
//
// channel  dir  tdata                                              tuser
// in_      in   [15:0] peer_id [31:16] peer_port [32] accepts      [1:0] req_type
// out_     out  [1:0] status [2] found [8:3] position [24:9] port  -
//               [25] entry_accepts [32:26] entry_count
//
// each item passes through accept, a compare step in every cell, then a
// reduce-and-update step in which inserts and removes shift the row tail by one slot
// the next item is taken while the previous result waits in the output register
// the update cycle holds while that register is still full and not taken
// rst_n clears the sequencer, the entry count and the output valid; cells keep contents
module sorted_peer_id_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // peer_id, peer_port, accepts_uploads, zero pad
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status, found, position, entry_port, entry_accepts,
                                  // entry_count, zero pad
);

  localparam int N = spit_pkg::TABLE_DEPTH;

  spit_pkg::state_t                 state_r, state_nxt;
  logic [spit_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [1:0]                       req_r;
  logic [spit_pkg::ID_W-1:0]        key_r;
  logic [spit_pkg::PORT_W-1:0]      port_r;
  logic                             acc_r;

  logic                             out_valid_r, out_valid_nxt;
  spit_pkg::status_t                res_status_r, res_status;
  logic                             res_found_r, res_found;
  logic [spit_pkg::POS_W-1:0]       res_pos_r, res_pos;
  logic [spit_pkg::PORT_W-1:0]      res_port_r, res_port;
  logic                             res_acc_r, res_acc;
  logic [spit_pkg::ECNT_W-1:0]      res_cnt_r;

  spit_pkg::cell_cmd_t              cmd;
  spit_pkg::entry_t                 new_ent;
  spit_pkg::entry_t [N-1:0]         ents;
  spit_pkg::entry_t [N-1:0]         left_ents;
  spit_pkg::entry_t [N-1:0]         right_ents;
  spit_pkg::flags_t [N-1:0]         flgs;
  spit_pkg::flags_t [N-1:0]         left_flgs;
  logic [N-1:0]                     lo_bnd;
  logic [N-1:0]                     up_bnd;
  logic [N-1:0]                     eq_vec;

  logic                             lo_hit;
  logic [spit_pkg::IDX_W-1:0]       lo_pos;
  logic [spit_pkg::PORT_W-1:0]      lo_port;
  logic                             lo_acc;
  logic [spit_pkg::IDX_W-1:0]       up_pos;

  logic                             in_fire;
  logic                             fire;
  logic                             is_ins;
  logic                             is_rem;
  logic                             full;

  assign new_ent.id   = key_r;
  assign new_ent.port = port_r;
  assign new_ent.acc  = acc_r;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign left_ents[gi] = '0;
        assign left_flgs[gi] = '0;
      end else begin : g_mid
        assign left_ents[gi] = ents[gi-1];
        assign left_flgs[gi] = flgs[gi-1];
      end
      if (gi == N - 1) begin : g_last
        assign right_ents[gi] = ents[gi];
      end else begin : g_body
        assign right_ents[gi] = ents[gi+1];
      end
      assign eq_vec[gi] = flgs[gi].eq;

      spit_cell u_cell (
        .clk       (clk),
        .idx       (spit_pkg::IDX_W'(gi)),
        .count     (count_r),
        .key       (key_r),
        .cmd       (cmd),
        .new_ent   (new_ent),
        .left_ent  (left_ents[gi]),
        .right_ent (right_ents[gi]),
        .left_flg  (left_flgs[gi]),
        .ent       (ents[gi]),
        .flg       (flgs[gi]),
        .lo_bnd    (lo_bnd[gi]),
        .up_bnd    (up_bnd[gi])
      );
    end
  endgenerate

  spit_reduce u_reduce (
    .lo_bnd  (lo_bnd),
    .up_bnd  (up_bnd),
    .eq      (eq_vec),
    .ents    (ents),
    .lo_hit  (lo_hit),
    .lo_pos  (lo_pos),
    .lo_port (lo_port),
    .lo_acc  (lo_acc),
    .up_pos  (up_pos)
  );

  assign in_tready = state_r == spit_pkg::S_IDLE;
  assign in_fire   = in_tvalid && in_tready;
  assign is_ins    = req_r == spit_pkg::REQ_INSERT;
  assign is_rem    = req_r == spit_pkg::REQ_REMOVE;
  assign full      = count_r == spit_pkg::CNT_W'(N);
  assign fire      = (state_r == spit_pkg::S_RES) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      spit_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = spit_pkg::S_CMP;
        end
      end
      spit_pkg::S_CMP: begin
        cmd.cap   = 1'b1;
        state_nxt = spit_pkg::S_RES;
      end
      spit_pkg::S_RES: begin
        if (fire) begin
          cmd.ins   = is_ins && !full;
          cmd.rem   = is_rem && lo_hit;
          state_nxt = spit_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spit_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_status = spit_pkg::ST_OK;
    res_found  = 1'b0;
    res_pos    = '0;
    res_port   = '0;
    res_acc    = 1'b0;
    count_nxt  = count_r;
    if (is_ins) begin
      if (full) begin
        res_status = spit_pkg::ST_FULL;
      end else begin
        res_found = 1'b1;
        res_pos   = spit_pkg::POS_W'(up_pos);
        res_port  = port_r;
        res_acc   = acc_r;
        count_nxt = count_r + spit_pkg::CNT_W'(1);
      end
    end else if (lo_hit) begin
      res_found = 1'b1;
      res_pos   = spit_pkg::POS_W'(lo_pos);
      res_port  = lo_port;
      res_acc   = lo_acc;
      if (is_rem) begin
        count_nxt = count_r - spit_pkg::CNT_W'(1);
      end
    end else begin
      res_status = spit_pkg::ST_MISS;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spit_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= in_tuser;
      key_r  <= spit_pkg::ID_W'(in_tdata[15:0]);
      port_r <= in_tdata[31:16];
      acc_r  <= in_tdata[32];
    end
    if (fire) begin
      res_status_r <= res_status;
      res_found_r  <= res_found;
      res_pos_r    <= res_pos;
      res_port_r   <= res_port;
      res_acc_r    <= res_acc;
      res_cnt_r    <= spit_pkg::ECNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_cnt_r, res_acc_r, res_port_r, res_pos_r, res_found_r,
                       res_status_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spit_pkg::CNT_W'(N))
    else $error("entry count above table depth");

  a_single_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spit_pkg::S_RES |-> $onehot0(lo_bnd) && $onehot0(up_bnd))
    else $error("more than one boundary cell");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + spit_pkg::CNT_W'(1))
    else $error("insert did not grow the table by one");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins || cmd.rem) |-> fire && !(cmd.ins && cmd.rem))
    else $error("row update outside the result cycle");

endmodule
